// ===== hdl/pfde_pkg.sv =====
// Shared types and constants for the page framebuffer draw engine.
package pfde_pkg;

    typedef enum logic [2:0] {
        CMD_FILL   = 3'd0,
        CMD_PIXEL  = 3'd1,
        CMD_CURSOR = 3'd2,
        CMD_GLYPH  = 3'd3,
        CMD_BITMAP = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_FONT_WIDTH  = 2'd0,
        CFG_FONT_HEIGHT = 2'd1
    } t_cfg_index;

    localparam logic [4:0]  FONT_WIDTH_RST  = 5'd7;
    localparam logic [6:0]  FONT_HEIGHT_RST = 7'd10;
    localparam logic [15:0] PIXEL_PATTERN   = 16'h8000;
    localparam logic [7:0]  BYTE_WHITE      = 8'hFF;
    localparam logic [7:0]  BYTE_BLACK      = 8'h00;
    localparam logic [4:0]  BITMAP_MAX      = 5'd8;

endpackage

// ===== hdl/page_framebuffer_draw_engine.sv =====
// Page framebuffer draw engine: framebuffer store, text cursor and command sequencer.
//
// Usage: drive a command on i_cmd and its fields, raise i_start; the transaction is
// taken at the clock edge where i_start is high and o_busy is low. Each command
// produces exactly one result, shown for one cycle with o_done high: o_status,
// o_read_data, o_cursor_col and o_cursor_row. The receiver cannot stall; o_done is
// a plain strobe and the result must be captured in that cycle.
// Configuration (font width, font height) goes over i_cfg_valid/i_cfg_index/
// i_cfg_data; o_cfg_ready is always high. Write it only while the engine is idle.
// Command flow (one memory port, one read-modify-write per pixel):
//   set cursor, rejected glyph, unused code, glyph row index too large: answered from idle
//   read byte: S_BYTE_RD then S_BYTE_OUT (answered from idle when out of range)
//   pixel, bitmap row, glyph row: S_PIX_RD then S_PIX_WR per drawn pixel, S_PIX_RD
//   alone per skipped pixel, and a last S_PIX_RD that reports the result
//   fill: a sweep over the whole store, one byte written per cycle
// o_busy drops in the cycle o_done is shown, so a new command may start there.
// Reset: a clearing pass writes zero to every byte with o_busy high and no
// result strobe; the cursor goes to 0,0 and the font to 7x10.
module page_framebuffer_draw_engine
    import pfde_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_x,
    input  logic [7:0]  i_y,
    input  logic        i_color,
    input  logic [15:0] i_bits,
    input  logic [5:0]  i_row_index,
    input  logic [3:0]  i_count,
    output logic        o_done,
    output logic        o_status,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_cursor_col,
    output logic [7:0]  o_cursor_row,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
    localparam logic [9:0] W_LIM = 10'(SCREEN_WIDTH);
    localparam logic [9:0] H_LIM = 10'(SCREEN_HEIGHT);
    localparam logic [7:0] PAGE_LIM = 8'(PAGE_COUNT);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_PIX_RD,
        S_PIX_WR,
        S_BYTE_RD,
        S_BYTE_OUT
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_sweep;
    logic [7:0]        r_fill;
    logic              r_report;
    logic [8:0]        r_x9;
    logic [7:0]        r_y;
    logic [15:0]       r_pat;
    logic [4:0]        r_cnt;
    logic              r_glyph;
    logic              r_color;
    logic [7:0]        r_cur_x;
    logic [7:0]        r_cur_y;
    logic [4:0]        r_font_w;
    logic [6:0]        r_font_h;
    logic              r_done;
    logic              r_status;
    logic [7:0]        r_read_data;
    logic [7:0]        r_mem_q;
    logic [7:0]        r_mem [STORE_SIZE];

    // Address unit shared by pixel and byte access: column + page * width.
    logic [12:0]       w_addr_full;
    logic [ADDR_W-1:0] w_pix_addr;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic              w_we;
    logic              w_in_range;
    logic              w_draw;
    logic              w_white;
    logic [7:0]        w_mask;
    logic [9:0]        w_sum_x;
    logic [9:0]        w_sum_y;
    logic              w_reject;

    assign w_addr_full = 13'(r_x9[7:0]) + 13'(r_y[7:3]) * 13'(SCREEN_WIDTH);
    assign w_pix_addr  = w_addr_full[ADDR_W-1:0];

    // Pixel step: glyphs paint every column, bitmaps only set bits.
    assign w_in_range = ({1'b0, r_x9} < W_LIM) && ({2'b0, r_y} < H_LIM);
    assign w_draw     = r_glyph || r_pat[15];
    assign w_white    = r_glyph ? (r_pat[15] ? r_color : ~r_color) : r_color;
    assign w_mask     = 8'd1 << r_y[2:0];

    assign w_we    = (r_state == S_SWEEP) || (r_state == S_PIX_WR);
    assign w_waddr = (r_state == S_SWEEP) ? r_sweep : w_pix_addr;
    assign w_wdata = (r_state == S_SWEEP) ? r_fill
                   : (w_white ? (r_mem_q | w_mask) : (r_mem_q & ~w_mask));

    // Fit check for a character at the cursor.
    assign w_sum_x  = 10'(r_cur_x) + 10'(r_font_w);
    assign w_sum_y  = 10'(r_cur_y) + 10'(r_font_h);
    assign w_reject = (w_sum_x >= W_LIM) || (w_sum_y >= H_LIM);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_mem[w_pix_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_fill      <= BYTE_BLACK;
            r_report    <= 1'b0;
            r_cnt       <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_font_w    <= FONT_WIDTH_RST;
            r_font_h    <= FONT_HEIGHT_RST;
            r_done      <= 1'b0;
            r_status    <= 1'b0;
            r_read_data <= '0;
        end else begin
            r_done <= 1'b0;

            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_FONT_WIDTH:  r_font_w <= i_cfg_data[4:0];
                    CFG_FONT_HEIGHT: r_font_h <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_SWEEP: begin
                    if (r_sweep == LAST_ADDR) begin
                        r_done  <= r_report;
                        r_state <= S_IDLE;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_status    <= 1'b0;
                        r_read_data <= BYTE_BLACK;
                        r_color     <= i_color;
                        unique case (t_cmd'(i_cmd))
                            CMD_FILL: begin
                                r_fill   <= i_color ? BYTE_WHITE : BYTE_BLACK;
                                r_sweep  <= '0;
                                r_report <= 1'b1;
                                r_state  <= S_SWEEP;
                            end
                            CMD_PIXEL: begin
                                r_x9    <= {1'b0, i_x};
                                r_y     <= i_y;
                                r_pat   <= PIXEL_PATTERN;
                                r_cnt   <= 5'd1;
                                r_glyph <= 1'b0;
                                r_state <= S_PIX_RD;
                            end
                            CMD_CURSOR: begin
                                r_cur_x <= i_x;
                                r_cur_y <= i_y;
                                r_done  <= 1'b1;
                            end
                            CMD_GLYPH: begin
                                if (w_reject) begin
                                    r_status <= 1'b1;
                                    r_done   <= 1'b1;
                                end else if ({1'b0, i_row_index} < r_font_h) begin
                                    r_x9    <= {1'b0, r_cur_x};
                                    r_y     <= r_cur_y + {2'b00, i_row_index};
                                    r_pat   <= i_bits;
                                    r_cnt   <= r_font_w;
                                    r_glyph <= 1'b1;
                                    r_state <= S_PIX_RD;
                                    // Drawing uses the copy in r_x9; advance now.
                                    if ({1'b0, i_row_index} + 7'd1 == r_font_h) begin
                                        r_cur_x <= w_sum_x[7:0];
                                    end
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            CMD_BITMAP: begin
                                r_x9    <= {1'b0, i_x};
                                r_y     <= i_y;
                                r_pat   <= {i_bits[7:0], 8'h00};
                                r_cnt   <= (i_count > 4'd8) ? BITMAP_MAX : 5'(i_count);
                                r_glyph <= 1'b0;
                                r_state <= S_PIX_RD;
                            end
                            CMD_READ: begin
                                if ({1'b0, i_x} < W_LIM[8:0] && i_y < PAGE_LIM) begin
                                    // Page goes to r_y[7:3] so the address unit serves.
                                    r_x9    <= {1'b0, i_x};
                                    r_y     <= {1'b0, i_y[3:0], 3'b000};
                                    r_state <= S_BYTE_RD;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_PIX_RD: begin
                    if (r_cnt == 5'd0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_in_range && w_draw) begin
                        r_state <= S_PIX_WR;
                    end else begin
                        r_x9  <= r_x9 + 1'b1;
                        r_pat <= {r_pat[14:0], 1'b0};
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_PIX_WR: begin
                    r_x9    <= r_x9 + 1'b1;
                    r_pat   <= {r_pat[14:0], 1'b0};
                    r_cnt   <= r_cnt - 1'b1;
                    r_state <= S_PIX_RD;
                end
                S_BYTE_RD: begin
                    r_state <= S_BYTE_OUT;
                end
                S_BYTE_OUT: begin
                    r_read_data <= r_mem_q;
                    r_done      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_read_data  = r_read_data;
    assign o_cursor_col = r_cur_x;
    assign o_cursor_row = r_cur_y;

    // A result is only shown once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // Every accepted command either keeps the engine busy or reports at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted command neither busy nor done");

    // A rejected character never carries read data.
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_read_data == 8'h00))
        else $error("reject status with read data");

    // Store writes happen only in the sweep or the pixel write step; a pixel write step always follows a read step.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIX_WR) |-> $past(r_state == S_PIX_RD))
        else $error("pixel write without a read step");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the page framebuffer draw engine.
module tb_top
    import pfde_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Screen geometry for this run; the predictor and the DUT share it
    localparam int SCR_W        = 128;
    localparam int SCR_H        = 64;
    localparam int PAGES        = (SCR_H + 7) / 8;
    localparam int STORE_BYTES  = SCR_W * PAGES;
    // Longest quiet stretch is the clearing pass or a fill
    localparam int STALL_LIMIT  = 8000;
    // Drain a bit longer than the slowest glyph row, at width 31
    localparam int DRAIN_CYCLES = 80;
    localparam int DIR_ROWS     = 30;
    localparam int PHASES       = 7;

    // Command codes the package leaves unnamed; the engine must ignore them
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } t_draw_reply;

    // One command transaction; "typed" rows carry a hand-written reply
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        color;
        logic [15:0] bits;
        logic [5:0]  row_index;
        logic [3:0]  count;
        logic        typed;
        t_draw_reply want;
    } t_draw_cmd;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_start     = 1'b0;
    logic [2:0]  i_cmd       = '0;
    logic [7:0]  i_x         = '0;
    logic [7:0]  i_y         = '0;
    logic        i_color     = 1'b0;
    logic [15:0] i_bits      = '0;
    logic [5:0]  i_row_index = '0;
    logic [3:0]  i_count     = '0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data  = '0;
    logic        o_busy;
    logic        o_done;
    logic        o_status;
    logic [7:0]  o_read_data;
    logic [7:0]  o_cursor_col;
    logic [7:0]  o_cursor_row;
    logic        o_cfg_ready;

    page_framebuffer_draw_engine #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_color      (i_color),
        .i_bits       (i_bits),
        .i_row_index  (i_row_index),
        .i_count      (i_count),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_data  (o_read_data),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Shadow copy of the engine: page-organized image, text cursor, font size
    logic [7:0]  fb_image [STORE_BYTES];
    int unsigned pen_x;
    int unsigned pen_y;
    int unsigned glyph_w;
    int unsigned glyph_h;

    t_draw_reply replies_due [$];   // predicted replies, oldest first
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          items_sent     = 0;
    bit          no_gaps        = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Pixel (px, py) lives in bit py%8 of byte px + (py/8)*width; off-screen is dropped
    function automatic void plot_pixel(int unsigned px, int unsigned py, logic white);
        int unsigned addr;
        if (px >= SCR_W || py >= SCR_H) return;
        addr = px + (py / 8) * SCR_W;
        fb_image[addr][py % 8] = white;
    endfunction

    // Applies one accepted command to the shadow state and forms its reply
    task automatic apply_draw_command(input t_draw_cmd c, output t_draw_reply r);
        int unsigned k;
        int unsigned n;
        logic        on;
        r = '0;
        case (c.cmd)
            CMD_FILL: begin
                for (k = 0; k < STORE_BYTES; k++)
                    fb_image[k] = c.color ? BYTE_WHITE : BYTE_BLACK;
            end
            CMD_PIXEL: begin
                plot_pixel(c.x, c.y, c.color);
            end
            CMD_CURSOR: begin
                pen_x = c.x;
                pen_y = c.y;
            end
            CMD_GLYPH: begin
                // Whole character refused if its box touches the right or bottom edge
                if (pen_x + glyph_w >= SCR_W || pen_y + glyph_h >= SCR_H) begin
                    r.status = 1'b1;
                end else if (c.row_index < glyph_h) begin
                    // Columns past the 16 source bits draw as clear bits
                    for (k = 0; k < glyph_w; k++) begin
                        on = (k < 16) ? c.bits[15 - k] : 1'b0;
                        plot_pixel(pen_x + k, pen_y + c.row_index, on ? c.color : !c.color);
                    end
                    if (c.row_index + 1 == glyph_h)
                        pen_x = (pen_x + glyph_w) & 8'hFF;
                end
            end
            CMD_BITMAP: begin
                // Set bits only; each pixel clipped on its own, no column wrap
                n = (c.count > BITMAP_MAX) ? BITMAP_MAX : c.count;
                for (k = 0; k < n; k++)
                    if (c.bits[7 - k]) plot_pixel(c.x + k, c.y, c.color);
            end
            CMD_READ: begin
                if (c.x < SCR_W && c.y < PAGES)
                    r.read_data = fb_image[c.x + c.y * SCR_W];
            end
            default: ;
        endcase
        r.cursor_col = pen_x[7:0];
        r.cursor_row = pen_y[7:0];
    endtask

    // Drives one command after a random gap and waits for its transaction.
    // On return we sit on the accepting edge with i_start still high, so a
    // back-to-back command just overwrites the fields.
    task automatic send_cmd(input t_draw_cmd c);
        int          gap;
        t_draw_reply r;
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_cmd       <= c.cmd;
        i_x         <= c.x;
        i_y         <= c.y;
        i_color     <= c.color;
        i_bits      <= c.bits;
        i_row_index <= c.row_index;
        i_count     <= c.count;
        do @(posedge i_clk); while (o_busy);
        apply_draw_command(c, r);
        replies_due.push_back(c.typed ? c.want : r);
        items_sent++;
    endtask

    // Drop start and wait until every reply is in and the engine is idle
    task automatic settle();
        i_start <= 1'b0;
        while (replies_due.size() != 0 || o_busy) @(posedge i_clk);
    endtask

    // Writes font width then font height; valid stays high across both transactions
    task automatic set_font(input int unsigned w, input int unsigned h);
        int k;
        for (k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (k == 0) ? CFG_FONT_WIDTH : CFG_FONT_HEIGHT;
            i_cfg_data  <= (k == 0) ? w[6:0] : h[6:0];
            do @(posedge i_clk); while (!o_cfg_ready);
            if (k == 0) glyph_w = w & 5'h1F;
            else        glyph_h = h & 7'h7F;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Whole characters most often (cursor, then rows 0..h-1 in order), plus
    // scattered pixels, bitmaps, reads, rare fills and some noise
    task automatic random_phase(input int target);
        t_draw_cmd c;
        int        stop_at;
        int        pick;
        int        rows;
        int        k;
        logic      fits;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            pick        = $urandom_range(0, 99);
            c           = '0;
            c.color     = 1'($urandom_range(0, 1));
            c.bits      = 16'($urandom);
            c.row_index = 6'($urandom_range(0, 63));
            c.count     = 4'($urandom_range(0, 15));
            c.x         = 8'($urandom);
            c.y         = 8'($urandom);
            if (pick < 40) begin
                // Sometimes keep going from the advanced cursor
                if ($urandom_range(0, 4) != 0) begin
                    c.cmd = CMD_CURSOR;
                    if (glyph_w < SCR_W && glyph_h < SCR_H && $urandom_range(0, 7) != 0) begin
                        c.x = 8'($urandom_range(0, SCR_W - 1 - glyph_w));
                        c.y = 8'($urandom_range(0, SCR_H - 1 - glyph_h));
                    end
                    send_cmd(c);
                end
                fits = (pen_x + glyph_w < SCR_W) && (pen_y + glyph_h < SCR_H);
                rows = (fits && glyph_h != 0) ? glyph_h : $urandom_range(1, 2);
                c.cmd = CMD_GLYPH;
                for (k = 0; k < rows; k++) begin
                    c.bits = 16'($urandom);
                    if (fits && glyph_h != 0) c.row_index = 6'(k);
                    else                      c.row_index = 6'($urandom_range(0, 63));
                    send_cmd(c);
                end
            end else if (pick < 55) begin
                c.cmd = CMD_PIXEL;
                if ($urandom_range(0, 4) != 0) begin
                    c.x = 8'($urandom_range(0, SCR_W - 1));
                    c.y = 8'($urandom_range(0, SCR_H - 1));
                end
                send_cmd(c);
            end else if (pick < 70) begin
                c.cmd = CMD_BITMAP;
                if ($urandom_range(0, 4) != 0) begin
                    c.x     = 8'($urandom_range(0, SCR_W + 3));
                    c.y     = 8'($urandom_range(0, SCR_H - 1));
                    c.count = 4'($urandom_range(1, 8));
                end
                send_cmd(c);
            end else if (pick < 90) begin
                c.cmd = CMD_READ;
                if ($urandom_range(0, 5) != 0) begin
                    c.x = 8'($urandom_range(0, SCR_W - 1));
                    c.y = 8'($urandom_range(0, PAGES - 1));
                end
                send_cmd(c);
            end else if (pick < 92) begin
                c.cmd = CMD_FILL;
                send_cmd(c);
            end else begin
                // Noise: unused codes, stray glyph rows, cursor anywhere
                case ($urandom_range(0, 3))
                    0:       c.cmd = CMD_SPARE_A;
                    1:       c.cmd = CMD_SPARE_B;
                    2:       c.cmd = CMD_GLYPH;
                    default: c.cmd = CMD_CURSOR;
                endcase
                send_cmd(c);
            end
        end
    endtask

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // Reply monitor: o_done marks one reply, taken at the edge that ends its cycle
    always @(posedge i_clk) begin
        t_draw_reply want;
        if (i_rst_n && o_done) begin
            if (replies_due.size() == 0) begin
                $display("%0t ns: reply with none expected, expected nothing, got %0d %0d %0d %0d",
                         $time, o_status, o_read_data, o_cursor_col, o_cursor_row);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("status",     want.status,     o_status);
                check_field("read_data",  want.read_data,  o_read_data);
                check_field("cursor_col", want.cursor_col, o_cursor_col);
                check_field("cursor_row", want.cursor_row, o_cursor_row);
            end
        end
    end

    // Watchdog: any transaction on either side restarts the count
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_draw_cmd   dir_tab [DIR_ROWS];
        int unsigned font_w_set [PHASES];
        int unsigned font_h_set [PHASES];
        int          phase_len  [PHASES];
        int          k;

        // Directed rows run at the reset font (7 x 10) on a cleared screen.
        // Hand-typed replies: reads of the cleared store, single pixels at the
        // corners, out-of-range reads, cursor stores, glyphs refused at the
        // right and bottom edges, and a read after a white fill.
        dir_tab = '{
            '{CMD_READ,    8'd0,   8'd0,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h00, 8'd0,   8'd0}},
            '{CMD_READ,    8'd127, 8'd7,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h00, 8'd0,   8'd0}},
            '{CMD_READ,    8'd128, 8'd0,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h00, 8'd0,   8'd0}},
            '{CMD_PIXEL,   8'd0,   8'd0,   1'b1, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h00, 8'd0,   8'd0}},
            '{CMD_READ,    8'd0,   8'd0,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h01, 8'd0,   8'd0}},
            '{CMD_PIXEL,   8'd127, 8'd63,  1'b1, 16'h0000, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_READ,    8'd127, 8'd7,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h80, 8'd0,   8'd0}},
            // Clipped pixels must not wrap into a neighbor byte
            '{CMD_PIXEL,   8'd128, 8'd0,   1'b1, 16'h0000, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_PIXEL,   8'd0,   8'd64,  1'b1, 16'h0000, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_PIXEL,   8'd0,   8'd0,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_READ,    8'd0,   8'd0,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h00, 8'd0,   8'd0}},
            '{CMD_CURSOR,  8'd255, 8'd255, 1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h00, 8'd255, 8'd255}},
            '{CMD_GLYPH,   8'd0,   8'd0,   1'b1, 16'hFFFF, 6'd0,  4'd0,  1'b1,
              '{1'b1, 8'h00, 8'd255, 8'd255}},
            '{CMD_CURSOR,  8'd121, 8'd0,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h00, 8'd121, 8'd0}},
            '{CMD_GLYPH,   8'd0,   8'd0,   1'b1, 16'hFFFF, 6'd0,  4'd0,  1'b1,
              '{1'b1, 8'h00, 8'd121, 8'd0}},
            '{CMD_CURSOR,  8'd0,   8'd54,  1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'h00, 8'd0,   8'd54}},
            '{CMD_GLYPH,   8'd0,   8'd0,   1'b1, 16'hFFFF, 6'd0,  4'd0,  1'b1,
              '{1'b1, 8'h00, 8'd0,   8'd54}},
            // Character that just fits; row too large, then last row advances
            '{CMD_CURSOR,  8'd120, 8'd53,  1'b0, 16'h0000, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_GLYPH,   8'd0,   8'd0,   1'b1, 16'hA5C3, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_GLYPH,   8'd0,   8'd0,   1'b0, 16'hFFFF, 6'd63, 4'd0,  1'b0, '0},
            '{CMD_GLYPH,   8'd0,   8'd0,   1'b0, 16'h0000, 6'd9,  4'd0,  1'b0, '0},
            // Bitmaps: clipped at the corner, count above 8, count zero
            '{CMD_BITMAP,  8'd124, 8'd63,  1'b1, 16'hFFFF, 6'd0,  4'd8,  1'b0, '0},
            '{CMD_BITMAP,  8'd255, 8'd0,   1'b1, 16'h00FF, 6'd0,  4'd15, 1'b0, '0},
            '{CMD_BITMAP,  8'd3,   8'd3,   1'b1, 16'h00FF, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_READ,    8'd127, 8'd7,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_SPARE_A, 8'd255, 8'd255, 1'b1, 16'hFFFF, 6'd63, 4'd15, 1'b0, '0},
            '{CMD_SPARE_B, 8'd255, 8'd255, 1'b1, 16'hFFFF, 6'd63, 4'd15, 1'b0, '0},
            '{CMD_FILL,    8'd0,   8'd0,   1'b1, 16'h0000, 6'd0,  4'd0,  1'b0, '0},
            '{CMD_READ,    8'd64,  8'd4,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b1,
              '{1'b0, 8'hFF, 8'd127, 8'd53}},
            '{CMD_FILL,    8'd0,   8'd0,   1'b0, 16'h0000, 6'd0,  4'd0,  1'b0, '0}
        };

        // Font settings per random phase: all 16 source bits by 53 rows, smallest,
        // width past the 16 source bits, height that can never fit, zero size, and
        // two ordinary ones
        font_w_set = '{16, 1, 31, 16, 0, 8, 5};
        font_h_set = '{53, 1, 20, 64, 0, 8, 12};
        phase_len  = '{160, 150, 150, 120, 40, 160, 150};

        for (k = 0; k < STORE_BYTES; k++) fb_image[k] = 8'h00;
        pen_x   = 0;
        pen_y   = 0;
        glyph_w = FONT_WIDTH_RST;
        glyph_h = FONT_HEIGHT_RST;

        // Synchronous reset; the clearing pass afterward shows up as o_busy
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) send_cmd(dir_tab[k]);

        // Font registers change only with the engine idle and nothing pending
        for (k = 0; k < PHASES; k++) begin
            settle();
            set_font(font_w_set[k], font_h_set[k]);
            random_phase(phase_len[k]);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pfde_pkg.sv
hdl/page_framebuffer_draw_engine.sv
tb/tb_top.sv
